/* rtl/rde_pkg.sv */
// Shared types, constants and helper functions of the radix digit emitter.
package rde_pkg;

    // Value width taken from the request; higher bits are ignored
    localparam int VALUE_BITS  = 64;
    localparam int DIV_CNT_W   = $clog2(VALUE_BITS);
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int COUNT_W     = 7;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 7;

    // Input and output stream widths
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 8;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_OUT
    } state_t;

    // Control towards the serial divider
    typedef struct packed {
        logic start; // begin a new division pass
        logic load;  // take the dividend from the request, else keep the quotient
    } div_ctrl_t;

    // Status back from the serial divider
    typedef struct packed {
        logic               done;    // one-cycle mark: quotient and remainder final
        logic               nonzero; // quotient is not zero
        logic [DIGIT_W-1:0] rem;     // remainder, the new digit
    } div_stat_t;

    // Character tables
    localparam logic [CHAR_W-1:0] LOWER_DIGITS [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };
    localparam logic [CHAR_W-1:0] UPPER_DIGITS [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
    };

    // Bases below two count as two, above sixteen as sixteen
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_W'(2)) begin
            res = RADIX_W'(2);
        end else if (r > RADIX_W'(16)) begin
            res = RADIX_W'(16);
        end
        return res;
    endfunction

    // Digit to its ASCII character
    function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d,
                                                   input logic               up);
        return up ? UPPER_DIGITS[d] : LOWER_DIGITS[d];
    endfunction

endpackage

/* rtl/rde_divider.sv */
// Bit-serial restoring divider: value by radix, one quotient bit per cycle.
module rde_divider (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  rde_pkg::div_ctrl_t                   ctrl,
    input  logic [rde_pkg::VALUE_BITS-1:0]       dividend,
    input  logic [rde_pkg::RADIX_W-1:0]          radix,
    output rde_pkg::div_stat_t                   stat
);

    logic [rde_pkg::VALUE_BITS-1:0] q_reg, q_next;
    logic [rde_pkg::DIGIT_W-1:0]    rem_reg, rem_next;
    logic [rde_pkg::RADIX_W-1:0]    radix_reg, radix_next;
    logic [rde_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic                           nz_reg, nz_next;

    logic [rde_pkg::RADIX_W-1:0] trial;
    logic [rde_pkg::RADIX_W-1:0] diff;
    logic                        ge;

    // One shift-subtract step
    assign trial = {rem_reg, q_reg[rde_pkg::VALUE_BITS-1]};
    assign ge    = (trial >= radix_reg);
    assign diff  = ge ? (trial - radix_reg) : trial;

    // Next state of the shift registers and step counter
    always_comb begin
        q_next     = q_reg;
        rem_next   = rem_reg;
        radix_next = radix_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        nz_next    = nz_reg;
        if (ctrl.start) begin
            if (ctrl.load) begin
                q_next     = dividend;
                radix_next = radix;
            end
            rem_next  = '0;
            nz_next   = 1'b0;
            cnt_next  = rde_pkg::DIV_CNT_W'(rde_pkg::VALUE_BITS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next   = {q_reg[rde_pkg::VALUE_BITS-2:0], ge};
            rem_next = diff[rde_pkg::DIGIT_W-1:0];
            nz_next  = nz_reg | ge;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        q_reg     <= q_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
        cnt_reg   <= cnt_next;
        nz_reg    <= nz_next;
    end

    assign stat.done    = done_reg;
    assign stat.nonzero = nz_reg;
    assign stat.rem     = rem_reg;

endmodule

/* rtl/rde_digit_store.sv */
// Digit store: 64 four-bit entries, one write and one registered read port.
module rde_digit_store (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [rde_pkg::ADDR_W-1:0]       wr_addr,
    input  logic [rde_pkg::DIGIT_W-1:0]      wr_data,
    input  logic [rde_pkg::ADDR_W-1:0]       rd_addr,
    output logic [rde_pkg::DIGIT_W-1:0]      rd_data
);

    logic [rde_pkg::DIGIT_W-1:0] mem [rde_pkg::STORE_DEPTH];
    logic [rde_pkg::DIGIT_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/radix_digit_emitter.sv */
// Top level: unsigned value to ASCII digits in radix 2 to 16, most significant first.
//
//  Channel  Direction  tdata (low bit up)                          tlast
//  s_       in         value[63:0], radix[68:64], upper_case[69]   -
//  m_       out        digit_char[6:0]                             last_digit
//
//  Each digit comes from one pass of the bit-serial divider; the digits then
//  go out through the store's registered read, ST_RD then ST_OUT, for
//  n = 1 to 64 digits.
//  One request is worked at a time; s_tready is high once the last digit
//  sits in the output register. aresetn is synchronous, active low; the
//  digit store needs no clearing. m_tready low holds the output register.
module radix_digit_emitter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rde_pkg::S_TDATA_W-1:0]     s_tdata,  // value, radix, upper_case
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rde_pkg::M_TDATA_W-1:0]     m_tdata,  // digit_char, zero pad
    output logic                              m_tlast   // last_digit
);

    rde_pkg::state_t state_reg, state_next;

    logic [rde_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [rde_pkg::COUNT_W-1:0] idx_reg, idx_next;
    logic                        case_reg, case_next;
    logic                        m_valid_reg, m_valid_next;
    logic [rde_pkg::CHAR_W-1:0]  m_char_reg, m_char_next;
    logic                        m_last_reg, m_last_next;

    rde_pkg::div_ctrl_t          div_ctrl;
    rde_pkg::div_stat_t          div_stat;
    logic                        wr_en;
    logic [rde_pkg::ADDR_W-1:0]  rd_addr;
    logic [rde_pkg::DIGIT_W-1:0] rd_data;
    logic [rde_pkg::COUNT_W-1:0] count_inc;

    assign count_inc = count_reg + 1'b1;
    assign rd_addr   = rde_pkg::ADDR_W'(idx_reg - 1'b1);

    // Serial divider
    rde_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (s_tdata[rde_pkg::VALUE_BITS-1:0]),
        .radix    (rde_pkg::clamp_radix(s_tdata[68:64])),
        .stat     (div_stat)
    );

    // Digit store
    rde_digit_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[rde_pkg::ADDR_W-1:0]),
        .wr_data (div_stat.rem),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer: next state and outputs
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        case_next    = case_reg;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        div_ctrl     = '0;
        wr_en        = 1'b0;
        s_tready     = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            rde_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    div_ctrl.start = 1'b1;
                    div_ctrl.load  = 1'b1;
                    count_next     = '0;
                    case_next      = s_tdata[69];
                    state_next     = rde_pkg::ST_DIV;
                end
            end
            rde_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    wr_en      = 1'b1;
                    count_next = count_inc;
                    if (div_stat.nonzero &&
                        (count_inc < rde_pkg::COUNT_W'(rde_pkg::STORE_DEPTH))) begin
                        div_ctrl.start = 1'b1;
                    end else begin
                        idx_next   = count_inc;
                        state_next = rde_pkg::ST_RD;
                    end
                end
            end
            rde_pkg::ST_RD: begin
                state_next = rde_pkg::ST_OUT;
            end
            rde_pkg::ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_char_next  = rde_pkg::to_ascii(rd_data, case_reg);
                    m_last_next  = (idx_reg == rde_pkg::COUNT_W'(1));
                    idx_next     = idx_reg - 1'b1;
                    state_next   = (idx_reg == rde_pkg::COUNT_W'(1)) ?
                                   rde_pkg::ST_IDLE : rde_pkg::ST_RD;
                end
            end
            default: begin
                state_next = rde_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rde_pkg::ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        case_reg   <= case_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = rde_pkg::M_TDATA_W'(m_char_reg);
    assign m_tlast  = m_last_reg;

    // Digit count stays within the store
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= rde_pkg::COUNT_W'(rde_pkg::STORE_DEPTH))
        else $error("digit count beyond store depth");

    // Emission never runs with nothing left to send
    a_idx_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rde_pkg::ST_RD || state_reg == rde_pkg::ST_OUT) |-> (idx_reg != '0))
        else $error("emission with empty digit index");

    // A finished division only arrives while dividing
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == rde_pkg::ST_DIV))
        else $error("divider done outside division phase");

    // Last digit loaded returns the sequencer to idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rde_pkg::ST_OUT && (!m_valid_reg || m_tready) &&
         idx_reg == rde_pkg::COUNT_W'(1)) |=> (state_reg == rde_pkg::ST_IDLE && m_tlast))
        else $error("last digit did not end the run");

endmodule
